@@ rtl/scba_pkg.sv @@
// Package for the size-class block allocator: beat structs, status and
// operation codes, controller states and the shift helpers.
// No dependencies.
package scba_pkg;

  localparam int ADDR_W   = 48;
  localparam int SIZE_W   = 32;
  localparam int LEN_W    = 33;
  localparam int CLS_W    = 3;
  localparam int SHIFT_W  = 4;
  localparam int NUM_REGS = 5;
  localparam int CFG_IDX_W = 3;

  localparam logic [SHIFT_W-1:0] SHIFT_MIN   = 4'd4;
  localparam logic [SHIFT_W-1:0] SHIFT_MAX   = 4'd12;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic [1:0] STATUS_POOL  = 2'd0;
  localparam logic [1:0] STATUS_LARGE = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic              func;
    logic [SIZE_W-1:0] req_size;
    logic [ADDR_W-1:0] fresh_page;
    logic [ADDR_W-1:0] user_pointer;
    logic [CLS_W-1:0]  hdr_class_in;
    logic [SIZE_W-1:0] hdr_size_in;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] result_address;
    logic [CLS_W-1:0]  hdr_class_out;
    logic [SIZE_W-1:0] hdr_size_out;
    logic              page_taken;
    logic [LEN_W-1:0]  heap_length;
  } out_item_t;

  typedef struct packed {
    logic               found;
    logic [CLS_W-1:0]   cls;
    logic [SHIFT_W-1:0] shift;
  } sel_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_POP
  } fsm_state_t;

  function automatic logic [SHIFT_W-1:0] shift_reset(input int idx);
    case (idx)
      0:       shift_reset = 4'd5;
      1:       shift_reset = 4'd7;
      2:       shift_reset = 4'd9;
      3:       shift_reset = 4'd10;
      4:       shift_reset = 4'd11;
      default: shift_reset = SHIFT_MAX;
    endcase
  endfunction

  function automatic logic [SHIFT_W-1:0] eff_shift(input logic [SHIFT_W-1:0] s);
    if (s < SHIFT_MIN) begin
      eff_shift = SHIFT_MIN;
    end else if (s > SHIFT_MAX) begin
      eff_shift = SHIFT_MAX;
    end else begin
      eff_shift = s;
    end
  endfunction

endpackage

@@ rtl/scba_class_sel.sv @@
// Size-class picker: first class whose block holds the request plus header.
// Depends on scba_pkg.
module scba_class_sel import scba_pkg::*; #(
  parameter int NUM_CLASSES = 5
) (
  input  logic [LEN_W-1:0]                    need_i,
  input  logic [NUM_CLASSES-1:0][SHIFT_W-1:0] shift_i,
  output sel_t                                sel_o
);

  always_comb begin
    sel_o = '0;
    for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
      if (need_i <= (LEN_W'(1) << shift_i[i])) begin
        sel_o.found = 1'b1;
        sel_o.cls   = CLS_W'(i);
        sel_o.shift = shift_i[i];
      end
    end
  end

endmodule

@@ rtl/scba_stack_ram.sv @@
// Free-stack storage: one write port, one read port, registered read data.
// Depends on scba_pkg for the data width.
module scba_stack_ram import scba_pkg::*; #(
  parameter int DEPTH = 1280,
  parameter int AW    = 11
) (
  input  logic              clk,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [ADDR_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [AW-1:0]     raddr_i,
  output logic [ADDR_W-1:0] rdata_o
);

  logic [ADDR_W-1:0] mem [DEPTH];
  logic [ADDR_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk) begin
    if (re_i) begin
      rdata_r <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_r;

endmodule

@@ rtl/size_class_block_allocator_unit.sv @@
// Size-class block allocator top level: controller, per-class counters and
// carving state. Depends on scba_pkg, scba_class_sel and scba_stack_ram.
//
// One operation at a time. A beat is taken when start is high and busy low.
// Its result is registered as the controller leaves the look state, or, for
// an allocate served from a free stack, as it leaves the pop state, which
// waits for the registered read of the stack memory. The result is then held
// on out_data with out_valid high for exactly one cycle. busy drops as the
// result is shown, so a new beat can be taken at the edge that ends the
// result cycle. The receiver cannot stall the result. PAGE_BYTES must be a
// power of two. Stack memory contents are not cleared at reset; only pushed
// entries are ever popped.
module size_class_block_allocator_unit import scba_pkg::*; #(
  parameter int NUM_CLASSES  = 5,
  parameter int PAGE_BYTES   = 4096,
  parameter int HEADER_BYTES = 12,
  parameter int STACK_DEPTH  = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  in_item_t             in_data,
  output logic                 out_valid,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SHIFT_W-1:0]   cfg_wdata
);

  localparam int CLW       = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int SW        = $clog2(STACK_DEPTH);
  localparam int CW        = $clog2(STACK_DEPTH + 1);
  localparam int LW        = $clog2(PAGE_BYTES / 16 + 1);
  localparam int AW        = CLW + SW;
  localparam int MEM_DEPTH = NUM_CLASSES * (2 ** SW);

  fsm_state_t state_r, state_nxt;
  in_item_t   item_r;
  out_item_t  out_r, out_nxt;
  logic       out_valid_r, out_valid_nxt;

  logic [SHIFT_W-1:0] shift_r [NUM_CLASSES];
  logic [CW-1:0]      count_r [NUM_CLASSES];
  logic [ADDR_W-1:0]  base_r  [NUM_CLASSES];
  logic [LW-1:0]      left_r  [NUM_CLASSES];

  logic [NUM_CLASSES-1:0][SHIFT_W-1:0] eff_w;
  sel_t               sel;
  logic [LEN_W-1:0]   need;
  logic               is_alloc, pool_free, use_cls;
  logic [CLW-1:0]     cidx;
  logic [CW-1:0]      cnt, count_nxt;
  logic               count_we, carve_we;
  logic [LW-1:0]      left, n_raw, n_blk, left_eff, left_nxt;
  logic [ADDR_W-1:0]  base_eff, block_c;
  logic [SHIFT_W-1:0] s;
  logic [LEN_W:0]     rnd_in, rnd;
  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [ADDR_W-1:0]  ram_wdata, ram_rdata;

  always_comb begin
    for (int i = 0; i < NUM_CLASSES; i++) begin
      eff_w[i] = eff_shift(shift_r[i]);
    end
  end

  assign is_alloc  = (item_r.func == FUNC_ALLOC);
  assign need      = {1'b0, item_r.req_size} + LEN_W'(HEADER_BYTES);
  assign pool_free = ({1'b0, item_r.hdr_class_in} < (CLS_W + 1)'(NUM_CLASSES));

  scba_class_sel #(.NUM_CLASSES(NUM_CLASSES)) u_sel (
    .need_i (need),
    .shift_i(eff_w),
    .sel_o  (sel)
  );

  assign use_cls = is_alloc ? sel.found : pool_free;
  assign cidx    = !use_cls ? '0 :
                   is_alloc ? sel.cls[CLW-1:0] : item_r.hdr_class_in[CLW-1:0];
  assign cnt     = count_r[cidx];
  assign left    = left_r[cidx];
  assign s       = sel.shift;

  // lazy carving: a fresh page is taken only when the current one is used up
  assign n_raw    = LW'(PAGE_BYTES >> s);
  assign n_blk    = (n_raw == '0) ? LW'(1) : n_raw;
  assign left_eff = (left == '0) ? n_blk : left;
  assign base_eff = (left == '0) ? item_r.fresh_page : base_r[cidx];
  assign left_nxt = left_eff - LW'(1);
  assign block_c  = base_eff + (ADDR_W'(left_nxt) << s);

  assign rnd_in = is_alloc ? {1'b0, need}
                           : ({2'b00, item_r.hdr_size_in} + (LEN_W + 1)'(HEADER_BYTES));
  assign rnd    = (rnd_in + (LEN_W + 1)'(PAGE_BYTES - 1)) & ~((LEN_W + 1)'(PAGE_BYTES - 1));

  always_comb begin
    state_nxt     = state_r;
    out_nxt       = out_r;
    out_valid_nxt = 1'b0;
    count_we      = 1'b0;
    count_nxt     = cnt;
    carve_we      = 1'b0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_waddr     = {cidx, cnt[SW-1:0]};
    ram_raddr     = {cidx, SW'(cnt - CW'(1))};
    ram_wdata     = item_r.user_pointer - ADDR_W'(HEADER_BYTES);
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        out_nxt = '0;
        if (is_alloc) begin
          out_nxt.hdr_size_out = item_r.req_size;
          if (!sel.found) begin
            out_nxt.status        = STATUS_LARGE;
            out_nxt.hdr_class_out = CLS_W'(NUM_CLASSES);
            out_nxt.heap_length   = rnd[LEN_W-1:0];
            out_valid_nxt         = 1'b1;
            state_nxt             = ST_IDLE;
          end else if (cnt != '0) begin
            count_we  = 1'b1;
            count_nxt = cnt - CW'(1);
            ram_re    = 1'b1;
            state_nxt = ST_POP;
          end else begin
            carve_we               = 1'b1;
            out_nxt.status         = STATUS_POOL;
            out_nxt.result_address = block_c + ADDR_W'(HEADER_BYTES);
            out_nxt.hdr_class_out  = sel.cls;
            out_nxt.page_taken     = (left == '0);
            out_valid_nxt          = 1'b1;
            state_nxt              = ST_IDLE;
          end
        end else begin
          if (!pool_free) begin
            out_nxt.status         = STATUS_LARGE;
            out_nxt.result_address = ram_wdata;
            out_nxt.heap_length    = rnd[LEN_W-1:0];
          end else if (cnt < CW'(STACK_DEPTH)) begin
            ram_we    = 1'b1;
            count_we  = 1'b1;
            count_nxt = cnt + CW'(1);
          end else begin
            out_nxt.status = STATUS_FULL;
          end
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_POP: begin
        out_nxt                = '0;
        out_nxt.status         = STATUS_POOL;
        out_nxt.result_address = ram_rdata + ADDR_W'(HEADER_BYTES);
        out_nxt.hdr_class_out  = sel.cls;
        out_nxt.hdr_size_out   = item_r.req_size;
        out_valid_nxt          = 1'b1;
        state_nxt              = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  scba_stack_ram #(.DEPTH(MEM_DEPTH), .AW(AW)) u_ram (
    .clk    (clk),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (state_r == ST_IDLE && start) begin
      item_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        shift_r[i] <= shift_reset(i);
        count_r[i] <= '0;
        base_r[i]  <= '0;
        left_r[i]  <= '0;
      end
    end else begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        if (cfg_we && i < NUM_REGS && cfg_index == CFG_IDX_W'(i)) begin
          shift_r[i] <= cfg_wdata;
        end
      end
      if (count_we) begin
        count_r[cidx] <= count_nxt;
      end
      if (carve_we) begin
        base_r[cidx] <= base_eff;
        left_r[cidx] <= left_nxt;
      end
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held for more than one cycle");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == ST_IDLE))
    else $error("result shown while an operation is in flight");

  a_pop_after_look: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_POP) |-> ($past(state_r) == ST_LOOK && $past(ram_re)))
    else $error("stack pop state without a memory read");

  a_accept_look: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (state_r == ST_LOOK))
    else $error("accepted beat not processed");

  for (genvar g = 0; g < NUM_CLASSES; g++) begin : g_cnt_chk
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
      count_r[g] <= CW'(STACK_DEPTH))
      else $error("free stack count beyond depth");
  end

endmodule
